>>> hdl/encoder_direction_speed_average_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the encoder direction / speed averaging block
// Implication checks on a clock, with an active-low reset
// that disables them.
// ----------------------------------------------------------------------------
`ifndef ENCODER_DIRECTION_SPEED_AVERAGE_MACROS_SVH
`define ENCODER_DIRECTION_SPEED_AVERAGE_MACROS_SVH

// same-cycle implication
`define EDSA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EDSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/edsa_pkg.sv
// ----------------------------------------------------------------------------
// edsa_pkg
// Types and fixed widths for the encoder direction / speed averaging block.
// ----------------------------------------------------------------------------
package edsa_pkg;

    localparam int POS_W      = 24;
    localparam int CPT_W      = 25;
    localparam int THR_W      = 24;
    localparam int SCALE_W    = 24;
    localparam int AVG_W      = 26;
    localparam int RPM_W      = 21;
    localparam int MAG_W      = 25;   // magnitude of one average
    localparam int DIFF_W     = 27;   // difference before clamping
    localparam int RPM_FRAC   = 16;   // Q16 rpm scale
    localparam int DELTA_LIMIT = 16777216;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_TURN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_THRESHOLD   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THRESHOLD = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_SCALE        = 8'd3;

    localparam logic [CPT_W-1:0]   CPT_RESET    = 25'd131072;
    localparam logic [THR_W-1:0]   WRAP_RESET   = 24'd100000;
    localparam logic [THR_W-1:0]   MOTION_RESET = 24'd1000;
    localparam logic [SCALE_W-1:0] SCALE_RESET  = 24'd60000;

    typedef enum logic [1:0] {
        DIR_UNKNOWN = 2'd0,
        DIR_CW      = 2'd1,
        DIR_CCW     = 2'd2
    } t_dir;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_WRAP,
        S_CLAMP,
        S_SUBOLD,
        S_ADDNEW,
        S_ABS,
        S_DIV,
        S_MUL,
        S_FMT
    } t_state;

endpackage

>>> hdl/edsa_alu.sv
// ----------------------------------------------------------------------------
// edsa_alu
// Shared adder/subtractor used by the arithmetic steps of the sequencer.
// ----------------------------------------------------------------------------
module edsa_alu #(
    parameter int W = 30
) (
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    input  edsa_pkg::t_alu_op   i_op,
    output logic signed [W-1:0] o_y
);
    import edsa_pkg::*;

    assign o_y = (i_op == ALU_SUB) ? (i_a - i_b) : (i_a + i_b);

endmodule

>>> hdl/encoder_direction_speed_average.sv
// Sequence: an accepted sample is evaluated in S_EVAL; while the direction is unknown it goes straight
//   to S_FMT, else on through S_WRAP, S_CLAMP, S_SUBOLD, S_ADDNEW, S_ABS, S_DIV, S_MUL and S_FMT.
//   A new sample is taken only in S_IDLE, after the last result is registered; result stalls hold S_FMT.
//   The serial divider (SUM_W - 1 steps, SUM_W = 26 + clog2(DEPTH)) and 25-step multiplier share one adder.
// Reset (synchronous): direction unknown, window counts cleared, registers at defaults;
//   the window memory is not cleared, entries are only read after being rewritten.
// ----------------------------------------------------------------------------
// encoder_direction_speed_average
// Direction detection, wrap-corrected position difference, moving average
// over up to DEPTH differences and Q16 rpm scaling with saturation.
// ----------------------------------------------------------------------------
`include "encoder_direction_speed_average_macros.svh"

module encoder_direction_speed_average #(
    parameter int DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // sample channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [edsa_pkg::POS_W-1:0]            i_position,
    input  logic                                  i_restart,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [edsa_pkg::AVG_W-1:0]     o_avg_delta,
    output logic signed [edsa_pkg::RPM_W-1:0]     o_speed_rpm,
    output logic [1:0]                            o_rotation,
    output logic                                  o_window_full,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [edsa_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [edsa_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import edsa_pkg::*;

    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = AVG_W + $clog2(DEPTH);
    localparam int MAGN_W     = SUM_W - 1;
    localparam int ALU_W      = SUM_W + 1;
    localparam int ITER_W     = $clog2(SUM_W);
    localparam int RPM_MAG_W  = 2 * MAG_W - RPM_FRAC;

    localparam logic signed [DIFF_W-1:0] DLIM_P = DIFF_W'(DELTA_LIMIT);
    localparam logic signed [DIFF_W-1:0] DLIM_N = -DLIM_P;
    localparam logic [RPM_MAG_W-1:0]     RPM_LIM = RPM_MAG_W'(1) << (RPM_W - 1);
    localparam logic signed [RPM_W-1:0]  RPM_MAX_V = {1'b0, {(RPM_W-1){1'b1}}};
    localparam logic signed [RPM_W-1:0]  RPM_MIN_V = {1'b1, {(RPM_W-1){1'b0}}};

    // configuration
    logic [CPT_W-1:0]   r_cpt,    n_cpt;
    logic [THR_W-1:0]   r_wrap,   n_wrap;
    logic [THR_W-1:0]   r_motion, n_motion;
    logic [SCALE_W-1:0] r_scale,  n_scale;

    // block state
    t_state             r_state, n_state;
    t_dir               r_dir,   n_dir;
    logic [POS_W-1:0]   r_last,  n_last;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0]   r_fill,  n_fill;
    logic               r_full,  n_full;
    logic [PTR_W-1:0]   r_wptr,  n_wptr;

    // working registers
    logic [POS_W-1:0]         r_pos,     n_pos;
    logic signed [DIFF_W-1:0] r_delta,   n_delta;
    logic                     r_add_cpt, n_add_cpt;
    logic                     r_sub_cpt, n_sub_cpt;
    logic                     r_zero,    n_zero;
    logic                     r_neg,     n_neg;
    logic [MAGN_W-1:0]        r_quo,     n_quo;
    logic [CNT_W-1:0]         r_rem,     n_rem;
    logic [CNT_W-1:0]         r_div,     n_div;
    logic [ITER_W-1:0]        r_iter,    n_iter;
    logic [MAG_W-1:0]         r_hi,      n_hi;
    logic [MAG_W-1:0]         r_lo,      n_lo;

    // result register
    logic                     r_out_valid, n_out_valid;
    logic signed [AVG_W-1:0]  r_out_avg,   n_out_avg;
    logic signed [RPM_W-1:0]  r_out_rpm,   n_out_rpm;
    t_dir                     r_out_rot,   n_out_rot;
    logic                     r_out_full,  n_out_full;

    // window memory
    logic signed [AVG_W-1:0]  r_win [DEPTH];
    logic signed [AVG_W-1:0]  r_old;
    logic                     w_win_we;

    // shared adder
    logic signed [ALU_W-1:0]  alu_a, alu_b, alu_y;
    t_alu_op                  alu_op;

    logic                     w_in_accept;
    logic                     w_det_gt, w_det_lt;
    logic [POS_W-1:0]         w_det_d;
    logic [CNT_W:0]           w_trial_in;
    logic [AVG_W-1:0]         w_mag_ext;
    logic signed [AVG_W-1:0]  w_avg;
    logic [2*MAG_W-1:0]       w_prod;
    logic [RPM_MAG_W-1:0]     w_rpm_mag;
    logic signed [RPM_W-1:0]  w_rpm;

    edsa_alu #(.W(ALU_W)) u_alu (
        .i_a  (alu_a),
        .i_b  (alu_b),
        .i_op (alu_op),
        .o_y  (alu_y)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign w_det_gt = (r_pos > r_last);
    assign w_det_lt = (r_pos < r_last);
    assign w_det_d  = w_det_gt ? (r_pos - r_last) : (r_last - r_pos);

    assign w_trial_in = {r_rem, r_quo[MAGN_W-1]};

    assign w_mag_ext = {1'b0, r_quo[MAG_W-1:0]};
    assign w_avg     = r_neg ? -w_mag_ext : w_mag_ext;

    // product magnitude scaled down; sign applied after, so truncation is toward zero
    assign w_prod    = {r_hi, r_lo};
    assign w_rpm_mag = w_prod[2*MAG_W-1:RPM_FRAC];

    always_comb begin
        if (!r_neg) begin
            w_rpm = (w_rpm_mag >= RPM_LIM) ? RPM_MAX_V : w_rpm_mag[RPM_W-1:0];
        end else begin
            w_rpm = (w_rpm_mag > RPM_LIM) ? RPM_MIN_V : -w_rpm_mag[RPM_W-1:0];
        end
    end

    always_comb begin
        n_cpt       = r_cpt;
        n_wrap      = r_wrap;
        n_motion    = r_motion;
        n_scale     = r_scale;
        n_state     = r_state;
        n_dir       = r_dir;
        n_last      = r_last;
        n_sum       = r_sum;
        n_fill      = r_fill;
        n_full      = r_full;
        n_wptr      = r_wptr;
        n_pos       = r_pos;
        n_delta     = r_delta;
        n_add_cpt   = r_add_cpt;
        n_sub_cpt   = r_sub_cpt;
        n_zero      = r_zero;
        n_neg       = r_neg;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_div       = r_div;
        n_iter      = r_iter;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_out_valid = r_out_valid;
        n_out_avg   = r_out_avg;
        n_out_rpm   = r_out_rpm;
        n_out_rot   = r_out_rot;
        n_out_full  = r_out_full;
        alu_a       = '0;
        alu_b       = '0;
        alu_op      = ALU_ADD;
        w_win_we    = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_COUNTS_PER_TURN:  n_cpt    = i_cfg_data;
                CFG_WRAP_THRESHOLD:   n_wrap   = i_cfg_data[THR_W-1:0];
                CFG_MOTION_THRESHOLD: n_motion = i_cfg_data[THR_W-1:0];
                CFG_RPM_SCALE:        n_scale  = i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_pos = i_position;
                    if (i_restart) begin
                        n_last = '0;
                        n_sum  = '0;
                        n_fill = '0;
                        n_full = 1'b0;
                        n_wptr = '0;
                    end
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_last = r_pos;
                if (r_dir == DIR_UNKNOWN) begin
                    // zero last position means nothing loaded yet
                    if (r_last != '0) begin
                        if (w_det_gt) begin
                            if (w_det_d > r_wrap) begin
                                n_dir = DIR_CCW;
                            end else if (w_det_d > r_motion) begin
                                n_dir = DIR_CW;
                            end
                        end else if (w_det_lt) begin
                            if (w_det_d > r_wrap) begin
                                n_dir = DIR_CW;
                            end else if (w_det_d > r_motion) begin
                                n_dir = DIR_CCW;
                            end
                        end
                    end
                    n_zero  = 1'b1;
                    n_state = S_FMT;
                end else begin
                    alu_a     = ALU_W'(r_pos);
                    alu_b     = ALU_W'(r_last);
                    alu_op    = ALU_SUB;
                    n_delta   = alu_y[DIFF_W-1:0];
                    n_add_cpt = (r_dir == DIR_CW) && w_det_lt;
                    n_sub_cpt = (r_dir == DIR_CCW) && w_det_gt;
                    n_zero    = 1'b0;
                    n_state   = S_WRAP;
                end
            end
            S_WRAP: begin
                alu_a  = ALU_W'(r_delta);
                alu_b  = ALU_W'(r_cpt);
                alu_op = r_add_cpt ? ALU_ADD : ALU_SUB;
                if (r_add_cpt || r_sub_cpt) begin
                    n_delta = alu_y[DIFF_W-1:0];
                end
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                if (r_delta > DLIM_P) begin
                    n_delta = DLIM_P;
                end else if (r_delta < DLIM_N) begin
                    n_delta = DLIM_N;
                end
                n_state = S_SUBOLD;
            end
            S_SUBOLD: begin
                // before the window is full the slot at the pointer is still empty
                alu_a   = ALU_W'(r_sum);
                alu_b   = r_full ? ALU_W'(r_old) : '0;
                alu_op  = ALU_SUB;
                n_sum   = alu_y[SUM_W-1:0];
                n_state = S_ADDNEW;
            end
            S_ADDNEW: begin
                alu_a    = ALU_W'(r_sum);
                alu_b    = ALU_W'(r_delta);
                alu_op   = ALU_ADD;
                n_sum    = alu_y[SUM_W-1:0];
                w_win_we = 1'b1;
                n_wptr   = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
                if (!r_full) begin
                    n_fill = r_fill + CNT_W'(1);
                    n_div  = r_fill + CNT_W'(1);
                    n_full = (r_fill == CNT_W'(DEPTH - 1));
                end else begin
                    n_div  = CNT_W'(DEPTH);
                end
                n_state = S_ABS;
            end
            S_ABS: begin
                alu_a  = '0;
                alu_b  = ALU_W'(r_sum);
                alu_op = ALU_SUB;
                n_neg  = r_sum[SUM_W-1];
                n_quo  = r_sum[SUM_W-1] ? alu_y[MAGN_W-1:0] : r_sum[MAGN_W-1:0];
                n_rem  = '0;
                n_iter = ITER_W'(MAGN_W - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                alu_a  = ALU_W'(w_trial_in);
                alu_b  = ALU_W'(r_div);
                alu_op = ALU_SUB;
                if (!alu_y[ALU_W-1]) begin
                    n_rem = alu_y[CNT_W-1:0];
                end else begin
                    n_rem = w_trial_in[CNT_W-1:0];
                end
                n_quo = {r_quo[MAGN_W-2:0], !alu_y[ALU_W-1]};
                if (r_iter == '0) begin
                    n_hi    = '0;
                    n_lo    = n_quo[MAG_W-1:0];
                    n_iter  = ITER_W'(MAG_W - 1);
                    n_state = S_MUL;
                end else begin
                    n_iter = r_iter - ITER_W'(1);
                end
            end
            S_MUL: begin
                // shift-add, multiplier bits consumed from r_lo
                alu_a  = ALU_W'(r_hi);
                alu_b  = r_lo[0] ? ALU_W'(r_scale) : '0;
                alu_op = ALU_ADD;
                n_hi   = alu_y[MAG_W:1];
                n_lo   = {alu_y[0], r_lo[MAG_W-1:1]};
                if (r_iter == '0) begin
                    n_state = S_FMT;
                end else begin
                    n_iter = r_iter - ITER_W'(1);
                end
            end
            S_FMT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_avg   = r_zero ? '0 : w_avg;
                    n_out_rpm   = r_zero ? '0 : w_rpm;
                    n_out_rot   = r_dir;
                    n_out_full  = r_full;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpt       <= CPT_RESET;
            r_wrap      <= WRAP_RESET;
            r_motion    <= MOTION_RESET;
            r_scale     <= SCALE_RESET;
            r_state     <= S_IDLE;
            r_dir       <= DIR_UNKNOWN;
            r_last      <= '0;
            r_sum       <= '0;
            r_fill      <= '0;
            r_full      <= 1'b0;
            r_wptr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cpt       <= n_cpt;
            r_wrap      <= n_wrap;
            r_motion    <= n_motion;
            r_scale     <= n_scale;
            r_state     <= n_state;
            r_dir       <= n_dir;
            r_last      <= n_last;
            r_sum       <= n_sum;
            r_fill      <= n_fill;
            r_full      <= n_full;
            r_wptr      <= n_wptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_delta    <= n_delta;
        r_add_cpt  <= n_add_cpt;
        r_sub_cpt  <= n_sub_cpt;
        r_zero     <= n_zero;
        r_neg      <= n_neg;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_iter     <= n_iter;
        r_hi       <= n_hi;
        r_lo       <= n_lo;
        r_out_avg  <= n_out_avg;
        r_out_rpm  <= n_out_rpm;
        r_out_rot  <= n_out_rot;
        r_out_full <= n_out_full;
    end

    always_ff @(posedge i_clk) begin
        if (w_win_we) begin
            r_win[r_wptr] <= r_delta[AVG_W-1:0];
        end
        r_old <= r_win[r_wptr];
    end

    assign o_out_valid   = r_out_valid;
    assign o_avg_delta   = r_out_avg;
    assign o_speed_rpm   = r_out_rpm;
    assign o_rotation    = r_out_rot;
    assign o_window_full = r_out_full;

    `EDSA_ASSERT_IMPL(a_full_fill, i_clk, i_rst_n, r_full, r_fill == CNT_W'(DEPTH), "full flag without full count")
    `EDSA_ASSERT_IMPL(a_ptr_fill, i_clk, i_rst_n, !r_full, r_wptr == r_fill[PTR_W-1:0], "write pointer off fill count while filling")
    `EDSA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_accept, o_in_stall, "sample channel not stalled after a transaction")
    `EDSA_ASSERT_IMPL(a_zero_unknown, i_clk, i_rst_n, o_out_valid && (o_rotation == DIR_UNKNOWN), (o_avg_delta == '0) && (o_speed_rpm == '0), "nonzero speed with unknown direction")

endmodule
